FILE: rtl/assert_macros.svh
// assertion helpers for the rtl files, included by the decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, quiet during reset
`define ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// implication checked in the cycle after the condition
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: rtl/ule_pkg.sv
`default_nettype none
package ule_pkg;

   localparam int unsigned MAX_VARINT_BYTES = 5;
   localparam int unsigned WORD_BYTES       = 4;

   // encoding format codes
   localparam logic [1:0] FMT_VARINT = 2'd0;
   localparam logic [1:0] FMT_LE     = 2'd1;
   localparam logic [1:0] FMT_BE     = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_OVERLONG  = 2'd2;

   localparam logic [2:0] VARINT_LAST = 3'(MAX_VARINT_BYTES);
   localparam logic [2:0] WORD_LAST   = 3'(WORD_BYTES);

   typedef struct packed {
      logic        emit;
      logic [31:0] value;
      logic [1:0]  status;
      logic [2:0]  used;
      logic [31:0] acc_next;
      logic [2:0]  pos_next;
   } dec_result_type;

endpackage
`default_nettype wire

FILE: rtl/ule_decode.sv
`default_nettype none
module ule_decode
   import ule_pkg::*;
(
   input  wire logic [1:0]     encoding_format,
   input  wire logic [31:0]    acc,
   input  wire logic [2:0]     pos,
   input  wire logic [7:0]     data_byte,
   input  wire logic           end_of_buffer,
   output dec_result_type      result
);

   logic [2:0]  p;
   logic [2:0]  u;
   logic [5:0]  shamt;
   logic [31:0] acc_new;
   logic        done;
   logic        overlong;

   always_comb begin
      p        = pos;
      u        = pos + 3'd1;
      shamt    = 6'd0;
      acc_new  = acc;
      done     = 1'b0;
      overlong = 1'b0;
      case (encoding_format)
         FMT_VARINT: begin
            if (pos >= VARINT_LAST) begin
               p = VARINT_LAST - 3'd1;
               u = VARINT_LAST;
            end
            // seven bits per group: 8p - p
            shamt   = ({3'b000, p} << 3) - {3'b000, p};
            acc_new = acc | ({25'd0, data_byte[6:0]} << shamt);
            if (!data_byte[7]) begin
               done = 1'b1;
            end else if (u >= VARINT_LAST) begin
               overlong = 1'b1;
            end
         end
         FMT_BE: begin
            if (pos >= WORD_LAST) begin
               u = WORD_LAST;
            end
            acc_new = {acc[23:0], data_byte};
            done    = (u >= WORD_LAST);
         end
         default: begin
            // little-endian, also the unused format code
            if (pos >= WORD_LAST) begin
               p = WORD_LAST - 3'd1;
               u = WORD_LAST;
            end
            shamt   = {1'b0, p[1:0], 3'b000};
            acc_new = acc | ({24'd0, data_byte} << shamt);
            done    = (u >= WORD_LAST);
         end
      endcase

      result.used     = u;
      result.acc_next = 32'd0;
      result.pos_next = 3'd0;
      result.emit     = 1'b1;
      result.value    = 32'd0;
      result.status   = ST_OK;
      if (overlong) begin
         result.status = ST_OVERLONG;
      end else if (done) begin
         result.value = acc_new;
      end else if (end_of_buffer) begin
         result.status = ST_TRUNCATED;
      end else begin
         result.emit     = 1'b0;
         result.acc_next = acc_new;
         result.pos_next = u;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/uint32_varint_or_endian_decoder.sv
// path: a byte word goes through the input register and the decode step into the result register at rsp_
// throughput: one byte word per cycle while the result register has room, bounded by the combinational decode step
// words that finish no value leave only the accumulator and byte count updated
// reset (synchronous, active high) selects varint format and drops any partial value
`default_nettype none
`include "assert_macros.svh"
module uint32_varint_or_endian_decoder
   import ule_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_encoding_format,
   // byte input channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_buffer,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_decoded_value,
   output logic [1:0]       rsp_decode_status,
   output logic [2:0]       rsp_bytes_used
);

   // format register and partial value state
   logic [1:0]  format_ff;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  pos_ff, pos_in;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_value_ff;
   logic [1:0]  out_status_ff;
   logic [2:0]  out_used_ff;

   dec_result_type dec;
   logic           out_free;
   logic           s1_fire;
   logic           req_fire;

   ule_decode u_decode (
      .encoding_format (format_ff),
      .acc             (acc_ff),
      .pos             (pos_ff),
      .data_byte       (s1_byte_ff),
      .end_of_buffer   (s1_last_ff),
      .result          (dec)
   );

   // the result register is free when empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   // a byte that finishes nothing needs no room downstream
   assign s1_fire   = s1_valid_ff && (!dec.emit || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (s1_fire && dec.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      acc_in = acc_ff;
      pos_in = pos_ff;
      if (csr_valid) begin
         // new format drops any partial value
         acc_in = 32'd0;
         pos_in = 3'd0;
      end else if (s1_fire) begin
         acc_in = dec.acc_next;
         pos_in = dec.pos_next;
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= FMT_VARINT;
         acc_ff       <= 32'd0;
         pos_ff       <= 3'd0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            format_ff <= csr_encoding_format;
         end
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_end_of_buffer;
      end
      if (s1_fire && dec.emit) begin
         out_value_ff  <= dec.value;
         out_status_ff <= dec.status;
         out_used_ff   <= dec.used;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_decoded_value = out_value_ff;
   assign rsp_decode_status = out_status_ff;
   assign rsp_bytes_used    = out_used_ff;

   // checks
   `ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && (rsp_decode_status != ST_OK),
      rsp_decoded_value == 32'd0, "error result carries a nonzero value")
   `ASSERT_IMP(a_used_range, clock, reset, rsp_valid,
      (rsp_bytes_used >= 3'd1) && (rsp_bytes_used <= VARINT_LAST), "bytes_used out of range")
   `ASSERT_IMP(a_overlong_five, clock, reset, rsp_valid && (rsp_decode_status == ST_OVERLONG),
      rsp_bytes_used == VARINT_LAST, "overlong result without five bytes")
   `ASSERT_IMP(a_pos_bound, clock, reset, 1'b1,
      pos_ff < VARINT_LAST, "partial byte count reached the varint limit")
   `ASSERT_NEXT(a_emit_lands, clock, reset, s1_fire && dec.emit,
      rsp_valid, "finished value did not reach the result register")

endmodule
`default_nettype wire

FILE: sim/uint32_varint_or_endian_decoder_checker.sv
module uint32_varint_or_endian_decoder_checker
   import ule_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_encoding_format,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_buffer,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [31:0] rsp_decoded_value,
   input  wire logic [1:0]  rsp_decode_status,
   input  wire logic [2:0]  rsp_bytes_used,
   output int unsigned      mismatch_count,
   output int unsigned      awaited_count
);

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
      logic [2:0]  used;
   } decode_word_type;

   // shadow of the block's format register and partial value
   logic [1:0]      fmt_shadow;
   logic [31:0]     acc_shadow;
   logic [2:0]      pos_shadow;
   decode_word_type awaited_decodes [$];

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
   end

   task automatic flag(input string what);
      $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   task automatic clear_partial();
      acc_shadow = '0;
      pos_shadow = '0;
   endtask

   // one byte word through the decoder, queueing the result it finishes
   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [2:0]      pos;
      logic [2:0]      used;
      logic            done;
      logic            overlong;
      decode_word_type res;
      pos      = pos_shadow;
      used     = pos_shadow + 3'd1;
      done     = 1'b0;
      overlong = 1'b0;
      if (fmt_shadow == FMT_VARINT) begin
         if (pos >= VARINT_LAST) begin
            pos  = VARINT_LAST - 3'd1;
            used = VARINT_LAST;
         end
         acc_shadow = acc_shadow | ({25'd0, b[6:0]} << (7 * pos));
         if (!b[7]) done = 1'b1;
         else if (used >= VARINT_LAST) overlong = 1'b1;
      end else begin
         if (pos >= WORD_LAST) begin
            pos  = WORD_LAST - 3'd1;
            used = WORD_LAST;
         end
         if (fmt_shadow == FMT_BE) acc_shadow = {acc_shadow[23:0], b};
         else acc_shadow = acc_shadow | ({24'd0, b} << (8 * pos));
         done = (used >= WORD_LAST);
      end

      if (overlong) begin
         res = '{value: 32'd0, status: ST_OVERLONG, used: used};
         awaited_decodes.push_back(res);
         clear_partial();
      end else if (done) begin
         res = '{value: acc_shadow, status: ST_OK, used: used};
         awaited_decodes.push_back(res);
         clear_partial();
      end else if (last) begin
         res = '{value: 32'd0, status: ST_TRUNCATED, used: used};
         awaited_decodes.push_back(res);
         clear_partial();
      end else begin
         pos_shadow = used;
      end
   endtask

   always @(posedge clock) begin : watch
      decode_word_type want;
      if (reset) begin
         fmt_shadow = FMT_VARINT;
         clear_partial();
         awaited_decodes.delete();
      end else begin
         // results first, so a word taken at this edge cannot match itself
         if (rsp_valid && rsp_ready) begin
            if (awaited_decodes.size() == 0) begin
               flag($sformatf("result %08h/%0d/%0d with nothing awaited",
                  rsp_decoded_value, rsp_decode_status, rsp_bytes_used));
            end else begin
               want = awaited_decodes.pop_front();
               if (rsp_decoded_value !== want.value)
                  flag($sformatf("value %08h, wanted %08h", rsp_decoded_value, want.value));
               if (rsp_decode_status !== want.status)
                  flag($sformatf("status %0d, wanted %0d", rsp_decode_status, want.status));
               if (rsp_bytes_used !== want.used)
                  flag($sformatf("bytes used %0d, wanted %0d", rsp_bytes_used, want.used));
            end
         end
         if (csr_valid && csr_ready) begin
            fmt_shadow = csr_encoding_format;
            clear_partial();
         end
         if (req_valid && req_ready) decode_byte(req_data_byte, req_end_of_buffer);
      end
      awaited_count <= awaited_decodes.size();
   end

endmodule

FILE: sim/tb_uint32_varint_or_endian_decoder.sv
module tb_uint32_varint_or_endian_decoder;
   import ule_pkg::*;

   localparam int unsigned BYTE_TARGET  = 750;     // random byte words to send
   localparam int unsigned CALM_FROM    = 650;     // no idling from here on
   localparam int unsigned CYCLE_LIMIT  = 400000;  // watchdog
   localparam int unsigned DRAIN_CYCLES = 8;       // covers the input and result registers with margin

   // the spare format code, decoded as little-endian
   localparam logic [1:0] FMT_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_encoding_format = FMT_VARINT;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_buffer = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_decoded_value;
   logic [1:0]  rsp_decode_status;
   logic [2:0]  rsp_bytes_used;

   int unsigned mismatch_count;
   int unsigned awaited_count;
   int unsigned cycle_count;
   int unsigned bytes_sent = 0;
   logic [1:0]  fmt_now = FMT_VARINT;
   logic        calm = 1'b0;   // set for the tail of the run: both sides stop idling

   uint32_varint_or_endian_decoder dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_encoding_format (csr_encoding_format),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_buffer   (req_end_of_buffer),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_decoded_value   (rsp_decoded_value),
      .rsp_decode_status   (rsp_decode_status),
      .rsp_bytes_used      (rsp_bytes_used)
   );

   uint32_varint_or_endian_decoder_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_encoding_format (csr_encoding_format),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_buffer   (req_end_of_buffer),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_decoded_value   (rsp_decoded_value),
      .rsp_decode_status   (rsp_decode_status),
      .rsp_bytes_used      (rsp_bytes_used),
      .mismatch_count      (mismatch_count),
      .awaited_count       (awaited_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: a run that outlives the limit is a failure
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("tb_uint32_varint_or_endian_decoder: errors");
      $finish;
   end

   // result side: ready in runs of random length, dropped at random between runs until calm
   initial begin : result_sink
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!calm && $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   // one byte word; returns at the edge that accepts it, valid still high
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_buffer <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // new format, only once every awaited result is out and the pipe has emptied
   task automatic write_format(input logic [1:0] f);
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid           <= 1'b1;
      csr_encoding_format <= f;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      fmt_now = f;
   endtask

   // one value in the current format: mostly well formed, some truncated,
   // some overlong varints and some raw noise; bit 8 of each entry is end of buffer
   task automatic send_value(input logic [1:0] fmt);
      logic [8:0]  seq [$];
      logic [31:0] v;
      logic [7:0]  grp;
      int unsigned kind;
      int unsigned minimal;
      int unsigned n;
      int unsigned cut;
      int unsigned last_ix;
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
         repeat ($urandom_range(1, 3)) seq.push_back(9'($urandom));
      end else if (fmt == FMT_VARINT && kind >= 80) begin
         // five bytes all carrying the continuation bit
         for (int i = 0; i < 5; i++) seq.push_back({1'b0, 1'b1, 7'($urandom)});
         if ($urandom_range(0, 1) == 1) seq[4] = seq[4] | 9'h100;
      end else begin
         // small magnitudes are common, full-width ones still appear
         v = $urandom >> $urandom_range(0, 31);
         if (fmt == FMT_VARINT) begin
            minimal = 1;
            while (minimal < 5 && (v >> (7 * minimal)) != 0) minimal++;
            // now and then a padded, non-minimal encoding
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(minimal, 5) : minimal;
            for (int i = 0; i < n; i++) begin
               grp = {1'b0, 7'(v >> (7 * i))};
               // junk above bit 31 in a fifth group must fall away
               if (i == 4 && $urandom_range(0, 2) == 0) grp[6:4] = 3'($urandom);
               if (i < n - 1) grp[7] = 1'b1;
               seq.push_back({1'b0, grp});
            end
         end else begin
            if ($urandom_range(0, 1) == 1) v = $urandom;
            for (int i = 0; i < 4; i++) seq.push_back({1'b0, 8'(v >> (8 * i))});
         end
         if (kind >= 70) begin
            // buffer ends part way through
            if (seq.size() == 1) begin
               seq[0] = seq[0] | 9'h080;
            end else begin
               cut = $urandom_range(1, seq.size() - 1);
               while (seq.size() > cut) seq.delete(seq.size() - 1);
            end
            last_ix = seq.size() - 1;
            seq[last_ix] = seq[last_ix] | 9'h100;
         end else if ($urandom_range(0, 3) == 0) begin
            // value completes on the final byte of the buffer
            last_ix = seq.size() - 1;
            seq[last_ix] = seq[last_ix] | 9'h100;
         end
      end
      foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
   endtask

   initial begin : stimulus
      logic [1:0]  fmt_order [4];
      int unsigned phase;
      int unsigned phase_end;
      fmt_order = '{FMT_VARINT, FMT_SPARE, FMT_BE, FMT_LE};
      phase     = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // varint after reset: zero, then the largest single byte ending the buffer
      send_byte(8'h00, 1'b0);
      send_byte(8'h7f, 1'b1);
      // all ones in five bytes
      repeat (4) send_byte(8'hff, 1'b0);
      send_byte(8'h0f, 1'b0);
      // overlong, with the fifth byte also the end of the buffer
      repeat (4) send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b1);
      // buffer ends mid varint
      send_byte(8'h80, 1'b0);
      send_byte(8'h81, 1'b1);
      // partial varint left hanging, then thrown away by the format write
      send_byte(8'haa, 1'b0);

      write_format(FMT_LE);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h04, 1'b1);
      send_byte(8'hff, 1'b1);

      write_format(FMT_BE);
      send_byte(8'hde, 1'b0);
      send_byte(8'had, 1'b0);
      send_byte(8'hbe, 1'b1);

      // random phases, every format code first in turn, then at random
      while (bytes_sent < BYTE_TARGET) begin
         write_format(phase < 4 ? fmt_order[phase] : 2'($urandom_range(0, 3)));
         phase++;
         phase_end = bytes_sent + $urandom_range(30, 90);
         while (bytes_sent < phase_end && bytes_sent < BYTE_TARGET) begin
            if (bytes_sent >= CALM_FROM && !calm) calm <= 1'b1;
            send_value(fmt_now);
         end
      end

      // drain: wait for every awaited word, then let the pipe settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_uint32_varint_or_endian_decoder: clean");
      end else begin
         $display("tb_uint32_varint_or_endian_decoder: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ule_pkg.sv
rtl/ule_decode.sv
rtl/uint32_varint_or_endian_decoder.sv
sim/uint32_varint_or_endian_decoder_checker.sv
sim/tb_uint32_varint_or_endian_decoder.sv
